/* design/ifrs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifrs_pkg
// Shared types and constants of the inverse fitness roulette selector.
// ----------------------------------------------------------------------------
package ifrs_pkg;

   localparam int POP_SIZE  = 64;
   localparam int ADDR_W    = $clog2(POP_SIZE);
   localparam int CNT_W     = $clog2(POP_SIZE + 1);
   localparam int INDEX_W   = 6;
   localparam int FIT_W     = 32;
   localparam int RAND_W    = 16;
   localparam int WEIGHT_W  = 48;
   localparam int SUM_W     = 56;
   localparam int ACC_W     = 64;
   localparam int QUO_W     = 41;
   localparam int BIT_W     = 6;
   localparam int HI_W      = SUM_W - RAND_W;

   localparam logic [1:0] ACT_LOAD   = 2'd0;
   localparam logic [1:0] ACT_SELECT = 2'd1;
   localparam logic [1:0] ACT_CLEAR  = 2'd2;

   localparam logic signed [WEIGHT_W-1:0] WEIGHT_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0]    SUM_MAX    = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0]    SUM_MIN    = {1'b1, {(SUM_W-1){1'b0}}};

   typedef struct packed {
      logic [1:0]              action;
      logic signed [FIT_W-1:0] fitness;
      logic                    entry_valid;
      logic [RAND_W-1:0]       random_fraction;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] selected_index;
      logic               fell_through;
   } rsp_type;

   typedef struct packed {
      logic load_start;
      logic div_step;
      logic write;
      logic clear;
      logic sel_start;
      logic mul;
      logic add;
      logic walk_step;
      logic rsp_hit;
      logic rsp_fall;
      logic rsp_empty;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic need_div;
      logic div_last;
      logic hit;
      logic last;
   } status_type;

endpackage

/* design/ifrs_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifrs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ifrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/ifrs_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifrs_ctrl
// Controller state machine that sequences load, select and clear.
// ----------------------------------------------------------------------------
module ifrs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [1:0]          action,
   input  ifrs_pkg::status_type status,
   output ifrs_pkg::cmd_type    cmd,
   output logic                busy,
   output logic                rsp_strobe
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_DIV   = 7'b0000010,
      ST_WRITE = 7'b0000100,
      ST_MUL   = 7'b0001000,
      ST_ADD   = 7'b0010000,
      ST_WALK  = 7'b0100000,
      ST_RESP  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (action)
                  ifrs_pkg::ACT_LOAD: begin
                     if (!status.full) begin
                        cmd.load_start = 1'b1;
                        state_in = status.need_div ? ST_DIV : ST_WRITE;
                     end
                  end
                  ifrs_pkg::ACT_SELECT: begin
                     if (status.empty) begin
                        cmd.rsp_empty = 1'b1;
                        state_in = ST_RESP;
                     end else begin
                        cmd.sel_start = 1'b1;
                        state_in = ST_MUL;
                     end
                  end
                  ifrs_pkg::ACT_CLEAR: begin
                     cmd.clear = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.write = 1'b1;
            state_in = ST_IDLE;
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            cmd.add = 1'b1;
            state_in = ST_WALK;
         end
         ST_WALK: begin
            cmd.walk_step = 1'b1;
            if (status.hit) begin
               cmd.rsp_hit = 1'b1;
               state_in = ST_RESP;
            end else if (status.last) begin
               cmd.rsp_fall = 1'b1;
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = (state_ff == ST_RESP);

endmodule

/* design/ifrs_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifrs_dp
// Datapath: reciprocal divider, weight store, running sum and selection walk.
// ----------------------------------------------------------------------------
module ifrs_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  ifrs_pkg::req_type     req,
   input  ifrs_pkg::cmd_type     cmd,
   output ifrs_pkg::status_type  status,
   output ifrs_pkg::rsp_type     rsp
);

   logic [ifrs_pkg::FIT_W-1:0]              mag_ff, mag_in;
   logic                                   neg_ff;
   logic [ifrs_pkg::FIT_W-1:0]              rem_ff, rem_in;
   logic [ifrs_pkg::QUO_W-1:0]              quo_ff, quo_in;
   logic [ifrs_pkg::BIT_W-1:0]              bit_ff;
   logic signed [ifrs_pkg::WEIGHT_W-1:0]    wgt_ff;
   logic [ifrs_pkg::CNT_W-1:0]              count_ff;
   logic signed [ifrs_pkg::SUM_W-1:0]       sum_ff;
   logic [ifrs_pkg::RAND_W-1:0]             rand_ff;
   logic [ifrs_pkg::SUM_W-1:0]              smag_ff;
   logic                                   sneg_ff;
   logic [ifrs_pkg::SUM_W-1:0]              prod_hi_ff;
   logic [2*ifrs_pkg::RAND_W-1:0]           prod_lo_ff;
   logic signed [ifrs_pkg::ACC_W-1:0]       acc_ff;
   logic [ifrs_pkg::CNT_W-1:0]              rd_idx_ff;
   logic [ifrs_pkg::CNT_W-1:0]              chk_idx_ff;
   logic                                   dv_ff;
   ifrs_pkg::rsp_type                       rsp_ff;

   logic [ifrs_pkg::FIT_W:0]                rem_sh;
   logic                                   ge;
   logic [ifrs_pkg::QUO_W-1:0]              quo_next;
   logic signed [ifrs_pkg::WEIGHT_W-1:0]    wq;
   logic signed [ifrs_pkg::SUM_W:0]         sum_wide;
   logic signed [ifrs_pkg::SUM_W-1:0]       sum_sat;
   logic [ifrs_pkg::ACC_W-1:0]              t_mag;
   logic signed [ifrs_pkg::WEIGHT_W-1:0]    rd_w;
   logic signed [ifrs_pkg::ACC_W-1:0]       diff;
   logic                                   use_w;

   ifrs_ram #(
      .WIDTH(ifrs_pkg::WEIGHT_W),
      .DEPTH(ifrs_pkg::POP_SIZE)
   ) u_store (
      .clock  (clock),
      .wr_en  (cmd.write),
      .wr_addr(count_ff[ifrs_pkg::ADDR_W-1:0]),
      .wr_data(wgt_ff),
      .rd_addr(rd_idx_ff[ifrs_pkg::ADDR_W-1:0]),
      .rd_data(rd_w)
   );

   assign mag_in   = req.fitness[ifrs_pkg::FIT_W-1] ? (~req.fitness + 1'b1) : req.fitness;
   assign rem_sh   = {rem_ff, (bit_ff == ifrs_pkg::BIT_W'(ifrs_pkg::QUO_W - 1))};
   assign ge       = (rem_sh >= {1'b0, mag_ff});
   assign rem_in   = ge ? ifrs_pkg::FIT_W'(rem_sh - {1'b0, mag_ff})
                        : rem_sh[ifrs_pkg::FIT_W-1:0];
   assign quo_next = {quo_ff[ifrs_pkg::QUO_W-2:0], ge};
   assign quo_in   = quo_next;
   assign wq       = neg_ff ? -$signed(ifrs_pkg::WEIGHT_W'(quo_next))
                            : $signed(ifrs_pkg::WEIGHT_W'(quo_next));

   assign sum_wide = {sum_ff[ifrs_pkg::SUM_W-1], sum_ff}
                   + (ifrs_pkg::SUM_W+1)'(wgt_ff);
   always_comb begin
      if (sum_wide[ifrs_pkg::SUM_W] == sum_wide[ifrs_pkg::SUM_W-1]) begin
         sum_sat = sum_wide[ifrs_pkg::SUM_W-1:0];
      end else if (sum_wide[ifrs_pkg::SUM_W]) begin
         sum_sat = ifrs_pkg::SUM_MIN;
      end else begin
         sum_sat = ifrs_pkg::SUM_MAX;
      end
   end

   assign t_mag = ifrs_pkg::ACC_W'(prod_hi_ff)
                + ifrs_pkg::ACC_W'(prod_lo_ff[2*ifrs_pkg::RAND_W-1:ifrs_pkg::RAND_W]);

   assign use_w = dv_ff && (rd_w != '0);
   assign diff  = acc_ff - ifrs_pkg::ACC_W'(rd_w);

   assign status.full     = (count_ff == ifrs_pkg::CNT_W'(ifrs_pkg::POP_SIZE));
   assign status.empty    = (count_ff == '0);
   assign status.need_div = req.entry_valid && (req.fitness != '0);
   assign status.div_last = (bit_ff == '0);
   assign status.hit      = use_w && (diff[ifrs_pkg::ACC_W-1] || (diff == '0));
   assign status.last     = dv_ff && (chk_idx_ff == count_ff - 1'b1);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
      end else if (cmd.clear) begin
         count_ff <= '0;
         sum_ff   <= '0;
      end else if (cmd.write) begin
         count_ff <= count_ff + 1'b1;
         sum_ff   <= sum_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_start) begin
         mag_ff <= mag_in;
         neg_ff <= req.fitness[ifrs_pkg::FIT_W-1];
         rem_ff <= '0;
         quo_ff <= '0;
         bit_ff <= ifrs_pkg::BIT_W'(ifrs_pkg::QUO_W - 1);
         if (!req.entry_valid) begin
            wgt_ff <= '0;
         end else begin
            wgt_ff <= ifrs_pkg::WEIGHT_MAX;
         end
      end
      if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         bit_ff <= bit_ff - 1'b1;
         if (status.div_last) begin
            wgt_ff <= wq;
         end
      end
      if (cmd.sel_start) begin
         rand_ff <= req.random_fraction;
         sneg_ff <= sum_ff[ifrs_pkg::SUM_W-1];
         smag_ff <= sum_ff[ifrs_pkg::SUM_W-1] ? (~sum_ff + 1'b1) : sum_ff;
      end
      if (cmd.mul) begin
         prod_hi_ff <= smag_ff[ifrs_pkg::SUM_W-1:ifrs_pkg::RAND_W] * rand_ff;
         prod_lo_ff <= smag_ff[ifrs_pkg::RAND_W-1:0] * rand_ff;
      end
      if (cmd.add) begin
         acc_ff    <= sneg_ff ? -$signed(t_mag) : $signed(t_mag);
         rd_idx_ff <= '0;
         dv_ff     <= 1'b0;
      end
      if (cmd.walk_step) begin
         rd_idx_ff  <= rd_idx_ff + 1'b1;
         chk_idx_ff <= rd_idx_ff;
         dv_ff      <= 1'b1;
         if (use_w) begin
            acc_ff <= diff;
         end
      end
      if (cmd.rsp_hit) begin
         rsp_ff.selected_index <= ifrs_pkg::INDEX_W'(chk_idx_ff);
         rsp_ff.fell_through   <= 1'b0;
      end else if (cmd.rsp_fall) begin
         rsp_ff.selected_index <= ifrs_pkg::INDEX_W'(count_ff - 1'b1);
         rsp_ff.fell_through   <= 1'b1;
      end else if (cmd.rsp_empty) begin
         rsp_ff.selected_index <= '0;
         rsp_ff.fell_through   <= 1'b1;
      end
   end

   assign rsp = rsp_ff;

endmodule

/* design/inverse_fitness_roulette_select.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inverse_fitness_roulette_select
// Roulette selection weighted by the reciprocal of fitness.
// ----------------------------------------------------------------------------
// Load: with a valid nonzero fitness, the divider forms 41 quotient bits, one per cycle,
// then the weight is written; otherwise the weight is written directly. A load into a full store is dropped.
// Select: the walk reads one stored weight per cycle, and a result strobes once the walk
// ends at a hit or at the last entry; when empty, it strobes in the cycle after start.
// Clear empties the store. Reset empties the store; the receiver cannot stall.
module inverse_fitness_roulette_select (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  ifrs_pkg::req_type req_item,
   output logic              busy,
   output logic              rsp_strobe,
   output ifrs_pkg::rsp_type rsp_item
);

   ifrs_pkg::cmd_type    cmd;
   ifrs_pkg::status_type status;

   ifrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .action    (req_item.action),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_strobe(rsp_strobe)
   );

   ifrs_dp u_dp (
      .clock (clock),
      .reset (reset),
      .req   (req_item),
      .cmd   (cmd),
      .status(status),
      .rsp   (rsp_item)
   );

   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy) else $error("Result strobe while idle.");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe && !busy) else $error("Result not followed by idle.");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !busy && !rsp_strobe) else $error("Busy after reset.");

   a_hit_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.rsp_hit, cmd.rsp_fall, cmd.rsp_empty}))
      else $error("Conflicting result commands.");

endmodule
